@@ rtl/ifht_pkg.sv @@
// -----------------------------------------------------------------------------
// ifht_pkg: shared types and constants for the IPv6 fragment hole tracker
// Holds the controller state type, result codes and the command/status
// structs passed between controller and datapath.
// -----------------------------------------------------------------------------
package ifht_pkg;

    // Default sizes
    localparam int NUM_SLOTS_DEF = 32;
    localparam int MAX_HOLES_DEF = 16;

    // Field constants
    localparam logic [15:0] OFFSET_MASK = 16'hFFF8;
    localparam logic [15:0] LAST_INDEX  = 16'hFFFF;
    localparam logic [16:0] LEN_LIMIT   = 17'h10000;

    // Result status codes
    localparam logic [2:0] RES_STORED    = 3'd0;
    localparam logic [2:0] RES_COMPLETE  = 3'd1;
    localparam logic [2:0] RES_NO_OVERLAP = 3'd2;
    localparam logic [2:0] RES_SLOTS_FULL = 3'd3;
    localparam logic [2:0] RES_HOLES_FULL = 3'd4;
    localparam logic [2:0] RES_BAD_LENGTH = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_DECIDE,
        ST_CLAIM,
        ST_REC_RD,
        ST_REC_LOAD,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_WALK_DONE,
        ST_REMOVE,
        ST_PUSH_L,
        ST_PUSH_R,
        ST_FINISH,
        ST_RESP
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic       accept;
        logic       scan_step;
        logic       claim;
        logic       rec_read;
        logic       rec_load;
        logic       walk_rd;
        logic       walk_ev;
        logic       remove;
        logic       push_left;
        logic       push_right;
        logic       finish;
        logic       respond;
        logic       slot_zero;
        logic [2:0] code;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic bad_len;
        logic id_zero;
        logic scan_last;
        logic found;
        logic empty;
        logic walk_done;
        logic hit;
        logic need_left;
        logic need_right;
        logic store_full;
        logic cnt_zero;
        logic out_free;
    } sts_t;

endpackage

@@ rtl/ifht_if.sv @@
// -----------------------------------------------------------------------------
// ifht_if: request channels of the fragment hole tracker
// Fragment descriptor channel and result channel, valid/ready handshake.
// -----------------------------------------------------------------------------
interface ifht_frag_if;
    logic        valid;
    logic        ready;
    logic [31:0] frag_id;
    logic [15:0] byte_offset;
    logic [15:0] data_length;
    logic        more_fragments;

    modport source (output valid, frag_id, byte_offset, data_length, more_fragments,
                    input ready);
    modport sink   (input valid, frag_id, byte_offset, data_length, more_fragments,
                    output ready);
endinterface

interface ifht_result_if;
    logic        valid;
    logic        ready;
    logic [4:0]  slot_index;
    logic [2:0]  status;
    logic [16:0] total_length;

    modport source (output valid, slot_index, status, total_length, input ready);
    modport sink   (input valid, slot_index, status, total_length, output ready);
endinterface

@@ rtl/ifht_dp.sv @@
// -----------------------------------------------------------------------------
// ifht_dp: datapath of the fragment hole tracker
// Slot id store with busy bits, per-slot list records, hole memories,
// walk registers and the result register.
// -----------------------------------------------------------------------------
module ifht_dp #(
    parameter int NUM_SLOTS = ifht_pkg::NUM_SLOTS_DEF,
    parameter int MAX_HOLES = ifht_pkg::MAX_HOLES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  ifht_pkg::cmd_t   cmd,
    output ifht_pkg::sts_t   sts,
    input  logic [31:0]      frag_id,
    input  logic [15:0]      byte_offset,
    input  logic [15:0]      data_length,
    input  logic             more_fragments,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [4:0]       slot_index,
    output logic [2:0]       status,
    output logic [16:0]      total_length
);

    localparam int SW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int HW     = $clog2(MAX_HOLES);
    localparam int CW     = $clog2(MAX_HOLES + 1);
    localparam int HDEPTH = NUM_SLOTS * MAX_HOLES;
    localparam int HAW    = $clog2(HDEPTH);
    localparam int RW     = HW + CW + 17;

    // Memories
    logic [31:0]     id_mem    [NUM_SLOTS];
    logic [RW-1:0]   rec_mem   [NUM_SLOTS];
    logic [15:0]     first_mem [HDEPTH];
    logic [15:0]     last_mem  [HDEPTH];
    logic [HW-1:0]   link_mem  [HDEPTH];

    // Control state
    logic [NUM_SLOTS-1:0] busy_reg;
    logic                 scan_pend_reg;
    logic                 out_valid_reg;

    // Request registers
    logic [31:0]     id_reg;
    logic [15:0]     off_reg;
    logic [15:0]     len_reg;
    logic            mf_reg;

    // Scan registers
    logic [SW-1:0]   scan_idx_reg;
    logic [SW-1:0]   pidx_reg;
    logic [31:0]     id_rd_reg;
    logic            busy_rd_reg;
    logic            found_reg;
    logic            empty_reg;
    logic [SW-1:0]   found_idx_reg;
    logic [SW-1:0]   empty_idx_reg;
    logic [SW-1:0]   slot_reg;

    // List and walk registers
    logic [RW-1:0]   rec_rd_reg;
    logic [HW-1:0]   head_reg;
    logic [CW-1:0]   cnt_reg;
    logic [16:0]     final_reg;
    logic [HW-1:0]   cur_reg;
    logic [HW-1:0]   prev_reg;
    logic            prev_v_reg;
    logic [CW-1:0]   walk_i_reg;
    logic [MAX_HOLES-1:0] used_reg;
    logic [15:0]     hf_rd_reg;
    logic [15:0]     hl_rd_reg;
    logic [HW-1:0]   lk_rd_reg;
    logic            hit_reg;
    logic [HW-1:0]   hit_cur_reg;
    logic [HW-1:0]   hit_prev_reg;
    logic            hit_pv_reg;
    logic [HW-1:0]   hit_link_reg;
    logic [15:0]     hf_reg;
    logic [15:0]     hl_reg;

    // Result registers
    logic [4:0]      res_slot_reg;
    logic [2:0]      res_status_reg;
    logic [16:0]     res_total_reg;

    logic [15:0]     last_w;
    logic [16:0]     end_w;
    logic [16:0]     final_next;
    logic [HW-1:0]   free_idx;
    logic [CW+1:0]   need_cnt;
    logic [SW+4:0]   slot_wide;
    logic            overlap;
    logic [HAW-1:0]  rd_addr;
    logic [HAW-1:0]  wr_addr;
    logic            fl_we;
    logic            lk_we;
    logic [15:0]     wr_first;
    logic [15:0]     wr_last;
    logic [HW-1:0]   wr_link;
    logic            rec_we;
    logic [SW-1:0]   rec_wa;
    logic [RW-1:0]   rec_wd;

    function automatic logic [HAW-1:0] haddr(input logic [SW-1:0] s, input logic [HW-1:0] h);
        haddr = HAW'(s) * HAW'(MAX_HOLES) + HAW'(h);
    endfunction

    // Derived fragment bounds
    assign last_w     = off_reg + len_reg - 16'd1;
    assign end_w      = {1'b0, off_reg} + {1'b0, len_reg};
    assign final_next = mf_reg ? final_reg : ({1'b0, last_w} + 17'd1);
    assign overlap    = (off_reg <= hl_rd_reg) && (last_w >= hf_rd_reg);

    // Lowest hole entry not on the list
    always_comb
    begin
        free_idx = '0;
        for (int i = MAX_HOLES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = HW'(i);
            end
        end
    end

    // Holes after the split plus one: count plus left and right, hit hole not taken off
    assign need_cnt = {2'b00, cnt_reg} + (CW+2)'(off_reg > hf_reg)
                      + (CW+2)'((last_w < hl_reg) && mf_reg);

    // Status to controller
    always_comb
    begin
        sts            = '0;
        sts.bad_len    = (len_reg == 16'd0) || (end_w > ifht_pkg::LEN_LIMIT);
        sts.id_zero    = (id_reg == 32'd0);
        sts.scan_last  = (scan_idx_reg == SW'(NUM_SLOTS - 1));
        sts.found      = found_reg;
        sts.empty      = empty_reg;
        sts.walk_done  = (walk_i_reg == cnt_reg);
        sts.hit        = hit_reg;
        sts.need_left  = off_reg > hf_reg;
        sts.need_right = (last_w < hl_reg) && mf_reg;
        sts.store_full = need_cnt > (CW+2)'(MAX_HOLES + 1);
        sts.cnt_zero   = (cnt_reg == '0);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // Hole memory port selection
    always_comb
    begin
        rd_addr  = haddr(slot_reg, cur_reg);
        wr_addr  = haddr(slot_reg, free_idx);
        fl_we    = 1'b0;
        lk_we    = 1'b0;
        wr_first = hf_reg;
        wr_last  = off_reg - 16'd1;
        wr_link  = head_reg;
        if (cmd.claim)
        begin
            wr_addr  = haddr(empty_idx_reg, '0);
            fl_we    = 1'b1;
            lk_we    = 1'b1;
            wr_first = 16'd0;
            wr_last  = ifht_pkg::LAST_INDEX;
            wr_link  = '0;
        end
        else if (cmd.remove)
        begin
            wr_addr = haddr(slot_reg, hit_prev_reg);
            lk_we   = hit_pv_reg;
            wr_link = hit_link_reg;
        end
        else if (cmd.push_left)
        begin
            fl_we = 1'b1;
            lk_we = 1'b1;
        end
        else if (cmd.push_right)
        begin
            fl_we    = 1'b1;
            lk_we    = 1'b1;
            wr_first = last_w + 16'd1;
            wr_last  = hl_reg;
        end
    end

    // Slot record port selection
    always_comb
    begin
        rec_we = cmd.claim || cmd.finish;
        rec_wa = cmd.claim ? empty_idx_reg : slot_reg;
        rec_wd = cmd.claim ? {HW'(0), CW'(1), 17'd0} : {head_reg, cnt_reg, final_next};
    end

    // Memories
    always_ff @(posedge clk)
    begin
        if (fl_we)
        begin
            first_mem[wr_addr] <= wr_first;
            last_mem[wr_addr]  <= wr_last;
        end
        if (lk_we)
        begin
            link_mem[wr_addr] <= wr_link;
        end
        hf_rd_reg <= first_mem[rd_addr];
        hl_rd_reg <= last_mem[rd_addr];
        lk_rd_reg <= link_mem[rd_addr];
        if (rec_we)
        begin
            rec_mem[rec_wa] <= rec_wd;
        end
        rec_rd_reg <= rec_mem[found_idx_reg];
        if (cmd.claim)
        begin
            id_mem[empty_idx_reg] <= id_reg;
        end
        id_rd_reg <= id_mem[scan_idx_reg];
    end

    // Control state: busy bits, scan pipeline flag, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= '0;
            scan_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scan_pend_reg <= cmd.scan_step;
            if (cmd.claim)
            begin
                busy_reg[empty_idx_reg] <= 1'b1;
            end
            else if (cmd.finish && (cnt_reg == '0))
            begin
                busy_reg[slot_reg] <= 1'b0;
            end
            if (cmd.respond)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            id_reg       <= frag_id;
            off_reg      <= byte_offset & ifht_pkg::OFFSET_MASK;
            len_reg      <= data_length;
            mf_reg       <= more_fragments;
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
            empty_reg    <= 1'b0;
        end
        if (cmd.scan_step)
        begin
            busy_rd_reg  <= busy_reg[scan_idx_reg];
            pidx_reg     <= scan_idx_reg;
            scan_idx_reg <= scan_idx_reg + SW'(1);
        end
        // first empty and first matching slot
        if (scan_pend_reg)
        begin
            if (!busy_rd_reg)
            begin
                if (!empty_reg)
                begin
                    empty_reg     <= 1'b1;
                    empty_idx_reg <= pidx_reg;
                end
            end
            else if ((id_rd_reg == id_reg) && !found_reg)
            begin
                found_reg     <= 1'b1;
                found_idx_reg <= pidx_reg;
            end
        end
        if (cmd.rec_read)
        begin
            slot_reg <= found_idx_reg;
        end
        if (cmd.claim || cmd.rec_load)
        begin
            walk_i_reg <= '0;
            used_reg   <= '0;
            hit_reg    <= 1'b0;
            prev_v_reg <= 1'b0;
        end
        if (cmd.claim)
        begin
            slot_reg  <= empty_idx_reg;
            head_reg  <= '0;
            cnt_reg   <= CW'(1);
            final_reg <= 17'd0;
            cur_reg   <= '0;
        end
        if (cmd.rec_load)
        begin
            {head_reg, cnt_reg, final_reg} <= rec_rd_reg;
            cur_reg <= rec_rd_reg[RW-1 -: HW];
        end
        // hole list walk step
        if (cmd.walk_ev)
        begin
            used_reg[cur_reg] <= 1'b1;
            if (!hit_reg && overlap)
            begin
                hit_reg      <= 1'b1;
                hit_cur_reg  <= cur_reg;
                hit_prev_reg <= prev_reg;
                hit_pv_reg   <= prev_v_reg;
                hit_link_reg <= lk_rd_reg;
                hf_reg       <= hf_rd_reg;
                hl_reg       <= hl_rd_reg;
            end
            else if (!hit_reg)
            begin
                prev_reg   <= cur_reg;
                prev_v_reg <= 1'b1;
            end
            cur_reg    <= lk_rd_reg;
            walk_i_reg <= walk_i_reg + CW'(1);
        end
        if (cmd.remove)
        begin
            used_reg[hit_cur_reg] <= 1'b0;
            if (!hit_pv_reg)
            begin
                head_reg <= hit_link_reg;
            end
            cnt_reg <= cnt_reg - CW'(1);
        end
        if (cmd.push_left || cmd.push_right)
        begin
            used_reg[free_idx] <= 1'b1;
            head_reg           <= free_idx;
            cnt_reg            <= cnt_reg + CW'(1);
        end
        if (cmd.finish)
        begin
            final_reg <= final_next;
        end
        if (cmd.respond)
        begin
            res_slot_reg   <= cmd.slot_zero ? 5'd0 : slot_wide[4:0];
            res_status_reg <= cmd.code;
            res_total_reg  <= (cmd.code == ifht_pkg::RES_COMPLETE) ? final_reg : 17'd0;
        end
    end

    assign slot_wide    = {5'd0, slot_reg};
    assign out_valid    = out_valid_reg;
    assign slot_index   = res_slot_reg;
    assign status       = res_status_reg;
    assign total_length = res_total_reg;

endmodule

@@ rtl/ifht_ctrl.sv @@
// -----------------------------------------------------------------------------
// ifht_ctrl: sequencing controller of the fragment hole tracker
// Steps one request through check, slot scan, claim or record load,
// hole walk, split and result.
// -----------------------------------------------------------------------------
module ifht_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ifht_pkg::sts_t   sts,
    output ifht_pkg::cmd_t   cmd
);

    ifht_pkg::state_t state_reg;
    ifht_pkg::state_t state_next;
    logic [2:0]       code_reg;
    logic [2:0]       code_next;
    logic             zslot_reg;
    logic             zslot_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ifht_pkg::ST_IDLE;
            code_reg  <= ifht_pkg::RES_STORED;
            zslot_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            zslot_reg <= zslot_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        zslot_next = zslot_reg;
        case (state_reg)
            ifht_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ifht_pkg::ST_CHECK;
                end
            end
            ifht_pkg::ST_CHECK:
            begin
                zslot_next = 1'b1;
                if (sts.bad_len)
                begin
                    code_next  = ifht_pkg::RES_BAD_LENGTH;
                    state_next = ifht_pkg::ST_RESP;
                end
                else if (sts.id_zero)
                begin
                    code_next  = ifht_pkg::RES_SLOTS_FULL;
                    state_next = ifht_pkg::ST_RESP;
                end
                else
                begin
                    state_next = ifht_pkg::ST_SCAN;
                end
            end
            ifht_pkg::ST_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = ifht_pkg::ST_SCAN_DRAIN;
                end
            end
            ifht_pkg::ST_SCAN_DRAIN:
            begin
                state_next = ifht_pkg::ST_DECIDE;
            end
            ifht_pkg::ST_DECIDE:
            begin
                if (sts.found)
                begin
                    zslot_next = 1'b0;
                    state_next = ifht_pkg::ST_REC_RD;
                end
                else if (sts.empty)
                begin
                    zslot_next = 1'b0;
                    state_next = ifht_pkg::ST_CLAIM;
                end
                else
                begin
                    code_next  = ifht_pkg::RES_SLOTS_FULL;
                    state_next = ifht_pkg::ST_RESP;
                end
            end
            ifht_pkg::ST_CLAIM:
            begin
                state_next = ifht_pkg::ST_WALK_RD;
            end
            ifht_pkg::ST_REC_RD:
            begin
                state_next = ifht_pkg::ST_REC_LOAD;
            end
            ifht_pkg::ST_REC_LOAD:
            begin
                state_next = ifht_pkg::ST_WALK_RD;
            end
            ifht_pkg::ST_WALK_RD:
            begin
                state_next = sts.walk_done ? ifht_pkg::ST_WALK_DONE : ifht_pkg::ST_WALK_EV;
            end
            ifht_pkg::ST_WALK_EV:
            begin
                state_next = ifht_pkg::ST_WALK_RD;
            end
            ifht_pkg::ST_WALK_DONE:
            begin
                if (!sts.hit)
                begin
                    code_next  = ifht_pkg::RES_NO_OVERLAP;
                    state_next = ifht_pkg::ST_RESP;
                end
                else if (sts.store_full)
                begin
                    code_next  = ifht_pkg::RES_HOLES_FULL;
                    state_next = ifht_pkg::ST_RESP;
                end
                else
                begin
                    state_next = ifht_pkg::ST_REMOVE;
                end
            end
            ifht_pkg::ST_REMOVE:
            begin
                if (sts.need_left)
                begin
                    state_next = ifht_pkg::ST_PUSH_L;
                end
                else if (sts.need_right)
                begin
                    state_next = ifht_pkg::ST_PUSH_R;
                end
                else
                begin
                    state_next = ifht_pkg::ST_FINISH;
                end
            end
            ifht_pkg::ST_PUSH_L:
            begin
                state_next = sts.need_right ? ifht_pkg::ST_PUSH_R : ifht_pkg::ST_FINISH;
            end
            ifht_pkg::ST_PUSH_R:
            begin
                state_next = ifht_pkg::ST_FINISH;
            end
            ifht_pkg::ST_FINISH:
            begin
                code_next  = sts.cnt_zero ? ifht_pkg::RES_COMPLETE : ifht_pkg::RES_STORED;
                state_next = ifht_pkg::ST_RESP;
            end
            ifht_pkg::ST_RESP:
            begin
                if (sts.out_free)
                begin
                    state_next = ifht_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ifht_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd           = '0;
        cmd.code      = code_reg;
        cmd.slot_zero = zslot_reg;
        in_ready      = 1'b0;
        case (state_reg)
            ifht_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            ifht_pkg::ST_SCAN:      cmd.scan_step  = 1'b1;
            ifht_pkg::ST_CLAIM:     cmd.claim      = 1'b1;
            ifht_pkg::ST_REC_RD:    cmd.rec_read   = 1'b1;
            ifht_pkg::ST_REC_LOAD:  cmd.rec_load   = 1'b1;
            ifht_pkg::ST_WALK_RD:   cmd.walk_rd    = !sts.walk_done;
            ifht_pkg::ST_WALK_EV:   cmd.walk_ev    = 1'b1;
            ifht_pkg::ST_REMOVE:    cmd.remove     = 1'b1;
            ifht_pkg::ST_PUSH_L:    cmd.push_left  = 1'b1;
            ifht_pkg::ST_PUSH_R:    cmd.push_right = 1'b1;
            ifht_pkg::ST_FINISH:    cmd.finish     = 1'b1;
            ifht_pkg::ST_RESP:      cmd.respond    = sts.out_free;
            default:
            begin
                cmd.accept = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/ipv6_fragment_hole_tracker_top.sv @@
// -----------------------------------------------------------------------------
// ipv6_fragment_hole_tracker_top: IPv6 reassembly hole list tracker
// Tracks open byte ranges per reassembly slot, one fragment request at a time.
//
// frag channel: one fragment descriptor per request (id, offset, length,
// more-fragments). result channel: one result per request giving the slot
// for the payload buffer, a status code and the total length on completion.
// A request is taken only while the block is idle; it is then checked,
// the slot ids are scanned one per cycle, the slot's hole list is walked
// one entry at a time, each read and then evaluated, and the split writes
// one hole per cycle. Early rejects go from the check straight to the
// result; the next request is taken the cycle after the result is registered.
// The slot scan and the hole list walk through the hole memory set the rate.
// Reset empties every slot at once; hole memories need no clearing.
// A stalled result is held in the output register, and a following request
// may be accepted and worked until its own result is due.
// -----------------------------------------------------------------------------
module ipv6_fragment_hole_tracker_top #(
    parameter int NUM_SLOTS = ifht_pkg::NUM_SLOTS_DEF,
    parameter int MAX_HOLES = ifht_pkg::MAX_HOLES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    ifht_frag_if.sink    frag,
    ifht_result_if.source result
);

    ifht_pkg::cmd_t cmd;
    ifht_pkg::sts_t sts;

    // Sequencer
    ifht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (frag.valid),
        .in_ready (frag.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Stores and arithmetic
    ifht_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .MAX_HOLES (MAX_HOLES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .frag_id        (frag.frag_id),
        .byte_offset    (frag.byte_offset),
        .data_length    (frag.data_length),
        .more_fragments (frag.more_fragments),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .slot_index     (result.slot_index),
        .status         (result.status),
        .total_length   (result.total_length)
    );

endmodule

@@ bench/ipv6_fragment_hole_tracker_top_test.sv @@
// -----------------------------------------------------------------------------
// ipv6_fragment_hole_tracker_top_test: self-checking bench for the hole tracker
// Fragment requests are queued up front and offered by a clocked driver. A
// clocked monitor takes the results and compares them, field by field, with
// the outcome that a local model of the slot table and hole lists predicts.
// -----------------------------------------------------------------------------
module ipv6_fragment_hole_tracker_top_test;

    localparam int SLOTS = 32;
    localparam int HOLES = 16;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [31:0] frag_id;
        logic [15:0] byte_offset;
        logic [15:0] data_length;
        logic        more_fragments;
    } frag_t;

    typedef struct packed {
        logic [4:0]  slot_index;
        logic [2:0]  status;
        logic [16:0] total_length;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ifht_frag_if   frag ();
    ifht_result_if result ();

    ipv6_fragment_hole_tracker_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .frag   (frag.sink),
        .result (result.source)
    );

    always #2 clk = ~clk;

    // Model state
    logic [31:0] m_ident [SLOTS];
    logic [15:0] m_first [SLOTS][HOLES];
    logic [15:0] m_last  [SLOTS][HOLES];
    int          m_link  [SLOTS][HOLES];
    int          m_head  [SLOTS];
    int          m_count [SLOTS];
    logic [16:0] m_final [SLOTS];

    frag_t    pending_frags [$];
    outcome_t expected_outcomes [$];
    int       fail_count = 0;
    int       send_idle = 29;
    int       recv_idle = 49;
    int       hold_cycles = 0;
    int       cycle_count = 0;
    logic     in_taken = 1'b0;

    // Push a hole at the list head, in the lowest free entry
    function automatic void push_hole(int s, logic [15:0] f, logic [15:0] l);
        bit used [HOLES];
        int cur;
        int e;
        cur = m_head[s];
        for (int i = 0; i < HOLES; i++) used[i] = 0;
        for (int i = 0; i < m_count[s]; i++)
        begin
            used[cur] = 1;
            cur = m_link[s][cur];
        end
        e = 0;
        while (e < HOLES && used[e]) e++;
        if (e >= HOLES) return;
        m_first[s][e] = f;
        m_last[s][e] = l;
        m_link[s][e] = m_head[s];
        m_head[s] = e;
        m_count[s]++;
    endfunction

    function automatic outcome_t reassemble(frag_t fr);
        outcome_t o;
        int found, empty, s, cur, prev, cnt;
        int off, len, first, last, hf, hl;
        bit hit, nl, nr;
        o = '0;
        off = fr.byte_offset & ifht_pkg::OFFSET_MASK;
        len = fr.data_length;
        found = -1;
        empty = -1;
        hit = 0;
        if (len == 0 || off + len > 65536)
        begin
            o.status = ifht_pkg::RES_BAD_LENGTH;
            return o;
        end
        if (fr.frag_id == 0)
        begin
            o.status = ifht_pkg::RES_SLOTS_FULL;
            return o;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (m_ident[i] == 0) begin if (empty < 0) empty = i; end
            else if (m_ident[i] == fr.frag_id && found < 0) found = i;
        end
        if (found < 0)
        begin
            if (empty < 0)
            begin
                o.status = ifht_pkg::RES_SLOTS_FULL;
                return o;
            end
            s = empty;
            m_ident[s] = fr.frag_id;
            m_first[s][0] = 16'h0;
            m_last[s][0] = ifht_pkg::LAST_INDEX;
            m_link[s][0] = 0;
            m_head[s] = 0;
            m_count[s] = 1;
            m_final[s] = '0;
        end
        else s = found;
        o.slot_index = s[4:0];
        first = off;
        last = off + len - 1;
        cnt = m_count[s];
        cur = m_head[s];
        prev = -1;
        for (int i = 0; i < cnt; i++)
        begin
            if (first <= m_last[s][cur] && last >= m_first[s][cur])
            begin
                hit = 1;
                break;
            end
            prev = cur;
            cur = m_link[s][cur];
        end
        if (!hit)
        begin
            o.status = ifht_pkg::RES_NO_OVERLAP;
            return o;
        end
        hf = m_first[s][cur];
        hl = m_last[s][cur];
        nl = first > hf;
        nr = (last < hl) && fr.more_fragments;
        if (cnt - 1 + nl + nr > HOLES)
        begin
            o.status = ifht_pkg::RES_HOLES_FULL;
            return o;
        end
        if (prev < 0) m_head[s] = m_link[s][cur];
        else m_link[s][prev] = m_link[s][cur];
        m_count[s]--;
        if (nl) push_hole(s, hf[15:0], 16'(first - 1));
        if (nr) push_hole(s, 16'(last + 1), hl[15:0]);
        if (!fr.more_fragments) m_final[s] = 17'(last + 1);
        if (m_count[s] == 0)
        begin
            m_ident[s] = 0;
            o.status = ifht_pkg::RES_COMPLETE;
            o.total_length = m_final[s];
        end
        else o.status = ifht_pkg::RES_STORED;
        return o;
    endfunction

    function automatic frag_t make_frag(logic [31:0] id, int off, int len, bit mf);
        frag_t f;
        f.frag_id = id;
        f.byte_offset = off[15:0];
        f.data_length = len[15:0];
        f.more_fragments = mf;
        return f;
    endfunction

    // Request handshake seen at the rising edge
    always @(posedge clk)
    begin
        in_taken <= rst_n && frag.valid && frag.ready;
    end

    // Driver: offers queued requests, predicts on acceptance, holds until taken
    always @(negedge clk)
    begin
        if (in_taken)
        begin
            expected_outcomes.push_back(reassemble(pending_frags.pop_front()));
        end
        if (!rst_n)
            frag.valid <= 1'b0;
        else if (pending_frags.size() > 0 &&
                 ((frag.valid && !in_taken) || $urandom_range(99) >= send_idle))
        begin
            frag.valid          <= 1'b1;
            frag.frag_id        <= pending_frags[0].frag_id;
            frag.byte_offset    <= pending_frags[0].byte_offset;
            frag.data_length    <= pending_frags[0].data_length;
            frag.more_fragments <= pending_frags[0].more_fragments;
        end
        else
            frag.valid <= 1'b0;
    end

    // Receiver ready, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            result.ready <= 1'b0;
        end
        else
            result.ready <= ($urandom_range(99) >= recv_idle);
    end

    // Monitor: compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        outcome_t exp_o;
        cycle_count <= cycle_count + 1;
        if (rst_n && result.valid && result.ready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("unexpected result slot %0d status %0d",
                       result.slot_index, result.status);
                fail_count = fail_count + 1;
            end
            else
            begin
                exp_o = expected_outcomes.pop_front();
                if (result.slot_index !== exp_o.slot_index)
                begin
                    $error("slot_index expected %0d actual %0d",
                           exp_o.slot_index, result.slot_index);
                    fail_count = fail_count + 1;
                end
                if (result.status !== exp_o.status)
                begin
                    $error("status expected %0d actual %0d", exp_o.status, result.status);
                    fail_count = fail_count + 1;
                end
                if (result.total_length !== exp_o.total_length)
                begin
                    $error("total_length expected %0d actual %0d",
                           exp_o.total_length, result.total_length);
                    fail_count = fail_count + 1;
                end
            end
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Random well-formed datagram: a few aligned pieces in random order
    task automatic queue_datagram(logic [31:0] id);
        int n, total, pieces [$];
        n = $urandom_range(1, 5);
        total = 8 * $urandom_range(1, 512);
        for (int i = 0; i < n; i++) pieces.push_back(i);
        pieces.shuffle();
        foreach (pieces[k])
        begin
            int lo, hi;
            lo = (total * pieces[k] / n) & ~7;
            hi = (pieces[k] == n - 1) ? total : ((total * (pieces[k] + 1) / n) & ~7);
            if (hi <= lo) continue;
            pending_frags.push_back(make_frag(id, lo, hi - lo, pieces[k] != n - 1));
        end
    endtask

    task automatic queue_noise(logic [31:0] id);
        int off, len;
        off = $urandom_range(0, 65535);
        len = ($urandom_range(3) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 2000);
        pending_frags.push_back(make_frag(id, off, len, $urandom_range(1)));
    endtask

    task automatic wait_drained();
        while (pending_frags.size() > 0 || frag.valid || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] ids [8];
        frag.valid = 1'b0;
        frag.frag_id = '0;
        frag.byte_offset = '0;
        frag.data_length = '0;
        frag.more_fragments = 1'b0;
        result.ready = 1'b0;
        for (int s = 0; s < SLOTS; s++)
        begin
            m_ident[s] = 0;
            m_head[s] = 0;
            m_count[s] = 0;
            m_final[s] = 0;
        end
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed: bad lengths, reserved id, whole datagram, overlap, splits
        pending_frags.push_back(make_frag(32'h1, 0, 0, 0));
        pending_frags.push_back(make_frag(32'h1, 65528, 9, 0));
        pending_frags.push_back(make_frag(32'h0, 0, 8, 1));
        pending_frags.push_back(make_frag(32'hFFFF_FFFF, 0, 65535, 1));
        pending_frags.push_back(make_frag(32'hFFFF_FFFF, 65528, 8, 0));
        pending_frags.push_back(make_frag(32'h2, 0, 65535, 0));
        pending_frags.push_back(make_frag(32'h3, 65535, 1, 0));
        pending_frags.push_back(make_frag(32'h3, 8, 8, 1));
        pending_frags.push_back(make_frag(32'h3, 8, 8, 1));
        pending_frags.push_back(make_frag(32'h3, 0, 8, 1));
        pending_frags.push_back(make_frag(32'h3, 16, 65519, 1));
        // Fill one slot's hole store with small gaps
        for (int k = 0; k < 17; k++)
            pending_frags.push_back(make_frag(32'h4, 16 * k + 8, 8, 1));
        // Every slot busy, then one more id
        for (int k = 0; k < 32; k++)
            pending_frags.push_back(make_frag(32'h100 + k, 8, 8, 1));
        pending_frags.push_back(make_frag(32'h200, 0, 8, 1));
        wait_drained();
        // Close every open slot so the random part has room
        for (int k = 0; k < 32; k++)
        begin
            pending_frags.push_back(make_frag(32'h100 + k, 0, 65535, 0));
            pending_frags.push_back(make_frag(32'h100 + k, 0, 65535, 1));
        end
        pending_frags.push_back(make_frag(32'h3, 0, 65535, 0));
        pending_frags.push_back(make_frag(32'h4, 0, 65535, 0));
        pending_frags.push_back(make_frag(32'h4, 0, 65535, 1));
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 29 : (phase == 1) ? 49 : 0;
            recv_idle = (phase == 0) ? 49 : (phase == 1) ? 29 : 0;
            if (phase == 1) hold_cycles = 600;
            while (pending_frags.size() < 380)
            begin
                for (int k = 0; k < 8; k++) ids[k] = $urandom() | 32'h1;
                for (int k = 0; k < 8; k++)
                    if ($urandom_range(9) < 8) queue_datagram(ids[k]);
                    else queue_noise($urandom_range(3) == 0 ? 32'h0 : ids[k]);
            end
            wait_drained();
        end
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
